>>> rtl/dlc_pkg.sv
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared types, constants and arithmetic helpers of the detector lag
// compensator: register codes, per-channel state row, core handshake structs.
// ----------------------------------------------------------------------------
package dlc_pkg;

    // Default number of detector channels.
    localparam int CHANNELS_DEF = 8;

    // Field widths of the stream payloads.
    localparam int CH_W   = 3;
    localparam int VAL_W  = 32;
    localparam int TDATA_W = 40;

    // Configuration port geometry.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Fraction bits of the coefficient and value formats.
    localparam int FRAC_COEF = 30;
    localparam int FRAC_VAL  = 16;

    // Multiplier operand and product widths.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 72;

    // Unity ratio in Q16.16.
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_DECAY_ONE     = 3'd0,
        REG_DECAY_TWO     = 3'd1,
        REG_STEP_GAIN_ONE = 3'd2,
        REG_STEP_GAIN_TWO = 3'd3,
        REG_RATIO_GAIN    = 3'd4,
        REG_BLEND_GAIN    = 3'd5
    } t_reg_idx;

    // Coefficient registers as seen by the datapath.
    typedef struct packed {
        logic [30:0]        decay_one;
        logic [30:0]        decay_two;
        logic signed [31:0] step_gain_one;
        logic signed [31:0] step_gain_two;
        logic [30:0]        ratio_gain;
        logic [30:0]        blend_gain;
    } t_coef;

    // Per-channel state row.
    typedef struct packed {
        logic signed [31:0] prev_raw;
        logic signed [31:0] prev_corrected;
        logic signed [31:0] prev_ratio;
        logic signed [31:0] term_one;
        logic signed [31:0] term_two;
    } t_row;

    // Item handed from the input channel to the core.
    typedef struct packed {
        logic               start;
        logic [CH_W-1:0]    channel;
        logic signed [31:0] raw_current;
    } t_req;

    // Result offered by the core to the output register.
    typedef struct packed {
        logic               valid;
        logic [CH_W-1:0]    channel;
        logic signed [31:0] value;
    } t_res;

    // Sequencer states of the core.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MSTART,
        S_MWAIT,
        S_FSUM,
        S_DSTART,
        S_DWAIT,
        S_WRITE,
        S_DONE
    } t_state;

    // Multiplications of one item, in issue order.
    typedef enum logic [2:0] {
        OP_K1A,
        OP_K1B,
        OP_K2A,
        OP_K2B,
        OP_Y,
        OP_A,
        OP_I
    } t_op;

    // Round half up, then shift right arithmetically by n bits.
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] half;
        half = PROD_W'(1) <<< (n - 1);
        return (v + half) >>> n;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [73:0] v);
        logic signed [31:0] r;
        if (v > 74'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -74'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/dlc_mul.sv
// ----------------------------------------------------------------------------
// dlc_mul
// Digit-serial signed multiplier: magnitudes are multiplied four bits of the
// second operand per cycle, then the sign is applied in a final step.
// ----------------------------------------------------------------------------
module dlc_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [dlc_pkg::MUL_W-1:0]       i_a,
    input  logic signed [dlc_pkg::MUL_W-1:0]       i_b,
    output logic                                   o_done,
    output logic signed [dlc_pkg::PROD_W-1:0]      o_prod
);

    localparam int HALF_W = dlc_pkg::PROD_W / 2;
    localparam int DIG_W  = 4;
    localparam int DIGITS = HALF_W / DIG_W;

    logic                      r_busy;
    logic [3:0]                r_cnt;
    logic                      r_neg;
    logic                      r_done;
    logic [HALF_W-1:0]         r_amag;
    logic [dlc_pkg::PROD_W-1:0] r_p;

    logic [HALF_W+DIG_W-1:0]   w_pp;
    logic [HALF_W+DIG_W-1:0]   w_sum;
    logic [dlc_pkg::MUL_W-1:0] w_amag;
    logic [dlc_pkg::MUL_W-1:0] w_bmag;

    // Operand magnitudes.
    assign w_amag = i_a[dlc_pkg::MUL_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_bmag = i_b[dlc_pkg::MUL_W-1] ? (~i_b + 1'b1) : i_b;

    // One digit partial product added into the upper half.
    assign w_pp  = {{DIG_W{1'b0}}, r_amag} * {{HALF_W{1'b0}}, r_p[DIG_W-1:0]};
    assign w_sum = {{DIG_W{1'b0}}, r_p[dlc_pkg::PROD_W-1:HALF_W]} + w_pp;

    // Shift-add sequence with a final sign correction step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_a[dlc_pkg::MUL_W-1] ^ i_b[dlc_pkg::MUL_W-1];
                r_amag <= HALF_W'(w_amag);
                r_p    <= {{HALF_W{1'b0}}, HALF_W'(w_bmag)};
            end else if (r_busy) begin
                if (r_cnt == 4'(DIGITS)) begin
                    r_p    <= r_neg ? (~r_p + 1'b1) : r_p;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_p   <= {w_sum, r_p[HALF_W-1:DIG_W]};
                    r_cnt <= r_cnt + 4'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

>>> rtl/dlc_div.sv
// ----------------------------------------------------------------------------
// dlc_div
// Bit-serial restoring divider for the ratio estimate: computes
// sat32(trunc(num * 65536 / den)) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int N_W = 32 + dlc_pkg::FRAC_VAL;

    logic               r_busy;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic               r_done;
    logic [N_W-1:0]     r_n;
    logic [31:0]        r_rem;
    logic [31:0]        r_d;
    logic signed [31:0] r_quot;

    logic [31:0] w_nmag;
    logic [31:0] w_dmag;
    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_nmag = i_num[31] ? (~i_num + 1'b1) : i_num;
    assign w_dmag = i_den[31] ? (~i_den + 1'b1) : i_den;

    // One restoring step.
    assign w_trial = {r_rem, r_n[N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[31] ^ i_den[31];
                r_n    <= {w_nmag, {dlc_pkg::FRAC_VAL{1'b0}}};
                r_rem  <= '0;
                r_d    <= w_dmag;
            end else if (r_busy) begin
                if (r_cnt == 6'(N_W)) begin
                    // Apply the sign and clamp to 32 bits.
                    if (!r_neg) begin
                        r_quot <= (r_n[N_W-1:31] != '0) ? 32'sh7FFF_FFFF : r_n[31:0];
                    end else if ((r_n[N_W-1:32] != '0) || (r_n[31] && (r_n[30:0] != '0))) begin
                        r_quot <= 32'sh8000_0000;
                    end else begin
                        r_quot <= ~r_n[31:0] + 32'd1;
                    end
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                    r_n   <= {r_n[N_W-2:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/dlc_core.sv
// ----------------------------------------------------------------------------
// dlc_core
// Per-item sequencer: for a channel in the bank, reads the channel state, runs
// the correction terms, ratio update and blend through the shared serial
// multiplier and divider, and writes the state back.
// ----------------------------------------------------------------------------
module dlc_core #(
    parameter int CHANNELS = dlc_pkg::CHANNELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dlc_pkg::t_req  i_req,
    input  dlc_pkg::t_coef i_coef,
    input  logic           i_take,
    output logic           o_idle,
    output dlc_pkg::t_res  o_res
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    dlc_pkg::t_state r_state, n_state;
    dlc_pkg::t_op    r_op, n_op;

    logic [dlc_pkg::CH_W-1:0] r_ch, n_ch;
    logic [AW-1:0]            r_idx, n_idx;
    logic signed [31:0]       r_raw, n_raw;
    logic signed [31:0]       r_pr, n_pr;
    logic signed [31:0]       r_pc, n_pc;
    logic signed [31:0]       r_y, n_y;
    logic signed [31:0]       r_t1, n_t1;
    logic signed [31:0]       r_t2, n_t2;
    logic signed [43:0]       r_sum, n_sum;
    logic signed [31:0]       r_k1, n_k1;
    logic signed [31:0]       r_k2, n_k2;
    logic signed [31:0]       r_f, n_f;
    logic signed [31:0]       r_a, n_a;
    logic signed [31:0]       r_res, n_res;
    logic [CHANNELS-1:0]      r_vld;

    dlc_pkg::t_row r_mem [CHANNELS];
    dlc_pkg::t_row r_rd;

    logic                                 w_mul_start;
    logic signed [dlc_pkg::MUL_W-1:0]     w_mul_a;
    logic signed [dlc_pkg::MUL_W-1:0]     w_mul_b;
    logic                                 w_mul_done;
    logic signed [dlc_pkg::PROD_W-1:0]    w_prod;
    logic signed [dlc_pkg::PROD_W-1:0]    w_r30;
    logic signed [dlc_pkg::PROD_W-1:0]    w_r16;
    logic                                 w_div_start;
    logic                                 w_div_done;
    logic signed [31:0]                   w_quot;
    logic signed [32:0]                   w_d;
    logic                                 w_write;
    logic                                 w_in_range;

    dlc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    dlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_f),
        .i_den   (r_pc),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Rounded product views and the raw current change.
    assign w_r30      = dlc_pkg::rnd_shift(w_prod, dlc_pkg::FRAC_COEF);
    assign w_r16      = dlc_pkg::rnd_shift(w_prod, dlc_pkg::FRAC_VAL);
    assign w_d        = 33'(r_raw) - 33'(r_pr);
    assign w_in_range = (int'(i_req.channel) < CHANNELS);

    // Multiplier operand selection by the current operation.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_op)
            dlc_pkg::OP_K1A: begin
                w_mul_a = 34'(r_t1);
                w_mul_b = $signed({3'b0, i_coef.decay_one});
            end
            dlc_pkg::OP_K1B: begin
                w_mul_a = 34'(w_d);
                w_mul_b = 34'(i_coef.step_gain_one);
            end
            dlc_pkg::OP_K2A: begin
                w_mul_a = 34'(r_t2);
                w_mul_b = $signed({3'b0, i_coef.decay_two});
            end
            dlc_pkg::OP_K2B: begin
                w_mul_a = 34'(w_d);
                w_mul_b = 34'(i_coef.step_gain_two);
            end
            dlc_pkg::OP_Y: begin
                w_mul_a = 34'(33'(w_quot) - 33'(r_y));
                w_mul_b = $signed({3'b0, i_coef.ratio_gain});
            end
            dlc_pkg::OP_A: begin
                w_mul_a = 34'(r_pc);
                w_mul_b = 34'(r_y);
            end
            dlc_pkg::OP_I: begin
                w_mul_a = 34'(33'(r_f) - 33'(r_a));
                w_mul_b = $signed({3'b0, i_coef.blend_gain});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Next state and datapath updates.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_ch    = r_ch;
        n_idx   = r_idx;
        n_raw   = r_raw;
        n_pr    = r_pr;
        n_pc    = r_pc;
        n_y     = r_y;
        n_t1    = r_t1;
        n_t2    = r_t2;
        n_sum   = r_sum;
        n_k1    = r_k1;
        n_k2    = r_k2;
        n_f     = r_f;
        n_a     = r_a;
        n_res   = r_res;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_write     = 1'b0;
        case (r_state)
            dlc_pkg::S_IDLE: begin
                if (i_req.start) begin
                    n_ch  = i_req.channel;
                    n_raw = i_req.raw_current;
                    n_idx = AW'(i_req.channel);
                    if (w_in_range) begin
                        n_state = dlc_pkg::S_LOAD;
                    end else begin
                        n_res   = '0;
                        n_state = dlc_pkg::S_DONE;
                    end
                end
            end
            dlc_pkg::S_LOAD: begin
                // A channel never written reads as its reset state.
                if (r_vld[r_idx]) begin
                    n_pr = r_rd.prev_raw;
                    n_pc = r_rd.prev_corrected;
                    n_y  = r_rd.prev_ratio;
                    n_t1 = r_rd.term_one;
                    n_t2 = r_rd.term_two;
                end else begin
                    n_pr = '0;
                    n_pc = '0;
                    n_y  = dlc_pkg::ONE_Q16;
                    n_t1 = '0;
                    n_t2 = '0;
                end
                n_op    = dlc_pkg::OP_K1A;
                n_state = dlc_pkg::S_MSTART;
            end
            dlc_pkg::S_MSTART: begin
                w_mul_start = 1'b1;
                n_state     = dlc_pkg::S_MWAIT;
            end
            dlc_pkg::S_MWAIT: begin
                if (w_mul_done) begin
                    n_state = dlc_pkg::S_MSTART;
                    case (r_op)
                        dlc_pkg::OP_K1A: begin
                            n_sum = 44'(w_r30);
                            n_op  = dlc_pkg::OP_K1B;
                        end
                        dlc_pkg::OP_K1B: begin
                            n_k1 = dlc_pkg::sat32(74'(r_sum) + 74'(w_r30));
                            n_op = dlc_pkg::OP_K2A;
                        end
                        dlc_pkg::OP_K2A: begin
                            n_sum = 44'(w_r30);
                            n_op  = dlc_pkg::OP_K2B;
                        end
                        dlc_pkg::OP_K2B: begin
                            n_k2    = dlc_pkg::sat32(74'(r_sum) + 74'(w_r30));
                            n_state = dlc_pkg::S_FSUM;
                        end
                        dlc_pkg::OP_Y: begin
                            n_y  = dlc_pkg::sat32(74'(r_y) + 74'(w_r30));
                            n_op = dlc_pkg::OP_A;
                        end
                        dlc_pkg::OP_A: begin
                            n_a  = dlc_pkg::sat32(74'(w_r16));
                            n_op = dlc_pkg::OP_I;
                        end
                        dlc_pkg::OP_I: begin
                            n_res   = dlc_pkg::sat32(74'(r_a) + 74'(w_r30));
                            n_state = dlc_pkg::S_WRITE;
                        end
                        default: begin
                            n_state = dlc_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dlc_pkg::S_FSUM: begin
                n_f = dlc_pkg::sat32(74'(r_raw) + 74'(r_k1) - 74'(r_k2));
                // With no previous correction the ratio is kept as it is.
                if (r_pc != '0) begin
                    n_state = dlc_pkg::S_DSTART;
                end else begin
                    n_op    = dlc_pkg::OP_A;
                    n_state = dlc_pkg::S_MSTART;
                end
            end
            dlc_pkg::S_DSTART: begin
                w_div_start = 1'b1;
                n_state     = dlc_pkg::S_DWAIT;
            end
            dlc_pkg::S_DWAIT: begin
                if (w_div_done) begin
                    n_op    = dlc_pkg::OP_Y;
                    n_state = dlc_pkg::S_MSTART;
                end
            end
            dlc_pkg::S_WRITE: begin
                w_write = 1'b1;
                n_state = dlc_pkg::S_DONE;
            end
            dlc_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = dlc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dlc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlc_pkg::S_IDLE;
            r_op    <= dlc_pkg::OP_K1A;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (w_write) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_ch  <= n_ch;
        r_idx <= n_idx;
        r_raw <= n_raw;
        r_pr  <= n_pr;
        r_pc  <= n_pc;
        r_y   <= n_y;
        r_t1  <= n_t1;
        r_t2  <= n_t2;
        r_sum <= n_sum;
        r_k1  <= n_k1;
        r_k2  <= n_k2;
        r_f   <= n_f;
        r_a   <= n_a;
        r_res <= n_res;
    end

    // Channel state memory: registered read at acceptance, write at the end.
    always_ff @(posedge i_clk) begin
        if (r_state == dlc_pkg::S_IDLE) begin
            r_rd <= r_mem[AW'(i_req.channel)];
        end
        if (w_write) begin
            r_mem[r_idx] <= '{prev_raw:       r_raw,
                              prev_corrected: r_res,
                              prev_ratio:     r_y,
                              term_one:       r_k1,
                              term_two:       r_k2};
        end
    end

    assign o_idle        = (r_state == dlc_pkg::S_IDLE);
    assign o_res.valid   = (r_state == dlc_pkg::S_DONE);
    assign o_res.channel = r_ch;
    assign o_res.value   = r_res;

endmodule

>>> rtl/detector_lag_compensator_top.sv
// ----------------------------------------------------------------------------
// detector_lag_compensator_top
// Removes the delayed response of a bank of self-powered neutron detectors,
// one corrected current per raw sample, with coefficient registers.
//
//   Channel   Direction  Handshake           Payload
//   s stream  in         i_s_tvalid/o_s_tready  channel, raw_current
//   m stream  out        o_m_tvalid/i_m_tready  out_channel, corrected_current
//   APB       in         psel/penable/pready    six coefficient registers
//
// An item runs from one input transaction to the earliest next one through the
// state read, four passes through the shared 4-bit-digit multiplier, the sum,
// the 48-step bit-serial divider and three more passes when the channel's
// previous corrected value is nonzero (else two passes and no division), then
// write back, hand-off and idle.
// One item is in work at a time; the next is taken once the result has moved
// to the output register, even while that register waits on i_m_tready.
// Reset is synchronous; all channels then read as their reset state.
// A channel at or above CHANNELS gives a zero result and leaves state alone.
// ----------------------------------------------------------------------------
module detector_lag_compensator_top #(
    parameter int CHANNELS = dlc_pkg::CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dlc_pkg::TDATA_W-1:0]        i_s_tdata,  // [2:0] channel, [34:3] raw_current
    // Output stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dlc_pkg::TDATA_W-1:0]        o_m_tdata,  // [2:0] out_channel, [34:3] corrected_current
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dlc_pkg::APB_AW-1:0]         paddr,
    input  logic [dlc_pkg::APB_DW-1:0]         pwdata,
    output logic [dlc_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    dlc_pkg::t_coef r_coef;
    dlc_pkg::t_req  w_req;
    dlc_pkg::t_res  w_res;
    logic           w_idle;
    logic           w_take;
    logic           w_wr;
    logic           r_ovalid;
    logic [dlc_pkg::CH_W-1:0] r_och;
    logic signed [31:0]       r_oval;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (w_wr) begin
            case (dlc_pkg::t_reg_idx'(paddr[4:2]))
                dlc_pkg::REG_DECAY_ONE:     r_coef.decay_one     <= pwdata[30:0];
                dlc_pkg::REG_DECAY_TWO:     r_coef.decay_two     <= pwdata[30:0];
                dlc_pkg::REG_STEP_GAIN_ONE: r_coef.step_gain_one <= pwdata;
                dlc_pkg::REG_STEP_GAIN_TWO: r_coef.step_gain_two <= pwdata;
                dlc_pkg::REG_RATIO_GAIN:    r_coef.ratio_gain    <= pwdata[30:0];
                dlc_pkg::REG_BLEND_GAIN:    r_coef.blend_gain    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (dlc_pkg::t_reg_idx'(paddr[4:2]))
            dlc_pkg::REG_DECAY_ONE:     prdata = {1'b0, r_coef.decay_one};
            dlc_pkg::REG_DECAY_TWO:     prdata = {1'b0, r_coef.decay_two};
            dlc_pkg::REG_STEP_GAIN_ONE: prdata = r_coef.step_gain_one;
            dlc_pkg::REG_STEP_GAIN_TWO: prdata = r_coef.step_gain_two;
            dlc_pkg::REG_RATIO_GAIN:    prdata = {1'b0, r_coef.ratio_gain};
            dlc_pkg::REG_BLEND_GAIN:    prdata = {1'b0, r_coef.blend_gain};
            default:                    prdata = '0;
        endcase
    end

    // Input transaction starts the core.
    assign o_s_tready        = w_idle;
    assign w_req.start       = i_s_tvalid && o_s_tready;
    assign w_req.channel     = i_s_tdata[2:0];
    assign w_req.raw_current = i_s_tdata[34:3];

    dlc_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_coef  (r_coef),
        .i_take  (w_take),
        .o_idle  (w_idle),
        .o_res   (w_res)
    );

    // Output register between the core and the output stream.
    assign w_take = w_res.valid && (!r_ovalid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_och  <= w_res.channel;
            r_oval <= w_res.value;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'b0, r_oval, r_och};

    // An accepted item keeps the input closed while it is in work.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // A result handed over is offered on the output next cycle.
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_m_tvalid)
        else $error("result taken but not offered");

    // Channels outside the bank give a zero result.
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (int'(o_m_tdata[2:0]) >= CHANNELS)) |-> (o_m_tdata[34:3] == '0))
        else $error("nonzero result for a channel outside the bank");

endmodule
